// ===== sv/pwec_pkg.sv =====
// ----------------------------------------------------------------------------
// pwec_pkg
// Shared types and constants for the position controller with endpoint cutoff.
// ----------------------------------------------------------------------------
package pwec_pkg;

  localparam int SENSOR_BITS        = 12;
  localparam int ERR_W              = SENSOR_BITS + 1;
  localparam int DELTA_W            = SENSOR_BITS + 2;
  localparam int TOTAL_W            = 32;
  localparam int CAP_W              = 31;
  localparam int DRIVE_W            = 8;
  localparam int DRIVE_LIMIT        = 127;
  localparam int GAIN_INT_BITS      = 4;
  localparam int GAIN_FRAC_BITS_DEF = 24;
  localparam int CFG_IDX_W          = 3;

  localparam int unsigned PROP_GAIN_RST  = 9227469;
  localparam int unsigned INTEG_GAIN_RST = 67;
  localparam int unsigned DERIV_GAIN_RST = 1509949;
  localparam int unsigned INTEG_ZONE_RST = 2;
  localparam int unsigned INTEG_CAP_RST  = 12500000;
  localparam int unsigned LOW_EP_RST     = 1170;
  localparam int unsigned HIGH_EP_RST    = 3000;
  localparam int unsigned CUT_BAND_RST   = 200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_INTEG_ZONE    = 3'd3,
    REG_INTEG_CAP     = 3'd4,
    REG_LOW_ENDPOINT  = 3'd5,
    REG_HIGH_ENDPOINT = 3'd6,
    REG_CUT_BAND      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SENSOR_BITS-1:0] target_position;
    logic [SENSOR_BITS-1:0] measured_position;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_level;
    logic                      endpoint_cut;
  } out_item_t;

  // first stage result handed to the multiply / scale stages
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [DELTA_W-1:0] delta;
    logic signed [TOTAL_W-1:0] total;
    logic                      cut;
  } upd_item_t;

  // per-stage load enables
  typedef struct packed {
    logic accept;
    logic en1;
    logic en2;
    logic en3;
    logic en_out;
  } pipe_ctl_t;

endpackage

// ===== sv/pid_with_endpoint_cutoff.sv =====
// ----------------------------------------------------------------------------
// pid_with_endpoint_cutoff
// Position PID with integral zone, capped error total and endpoint cutoff.
// ----------------------------------------------------------------------------
// One input word per control tick carries a target and a measured position;
// one result word comes back with the motor drive and the cutoff flag.
// Both channels are valid/ready. The config port writes one register per
// cycle at cfg_index when cfg_wr_en is high; write only while the block is
// idle.
// Pipeline: error/total update, three gain multiplies, sum (63 bits at the
// default gain width), then truncate/clamp into the output register. One
// word per cycle is sustained while out_ready stays high. The error total
// and last error update on the accepting edge, so back-to-back words see
// each other's state.
// Reset clears the controller state and the pipeline and loads the default
// gains, zone, cap, endpoints and band. When the receiver stalls, the
// result holds in the output register and empty stages behind it still
// fill; in_ready drops once every stage holds a word.
// ----------------------------------------------------------------------------
module pid_with_endpoint_cutoff #(
  parameter int GAIN_FRAC_BITS = pwec_pkg::GAIN_FRAC_BITS_DEF,
  localparam int GW    = GAIN_FRAC_BITS + pwec_pkg::GAIN_INT_BITS,
  localparam int CFG_W = (GW > pwec_pkg::CAP_W) ? GW : pwec_pkg::CAP_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pwec_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pwec_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [pwec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]                cfg_wdata
);
  import pwec_pkg::*;

  logic [GW-1:0]          prop_gain_r;
  logic [GW-1:0]          integ_gain_r;
  logic [GW-1:0]          deriv_gain_r;
  logic [SENSOR_BITS-1:0] integ_zone_r;
  logic [CAP_W-1:0]       integ_cap_r;
  logic [SENSOR_BITS-1:0] low_ep_r;
  logic [SENSOR_BITS-1:0] high_ep_r;
  logic [SENSOR_BITS-1:0] cut_band_r;

  logic      v1_r;
  logic      v2_r;
  logic      v3_r;
  logic      out_valid_r;
  pipe_ctl_t ctl;
  upd_item_t upd;

  always_comb begin
    ctl.en_out = !out_valid_r || out_ready;
    ctl.en3    = !v3_r || ctl.en_out;
    ctl.en2    = !v2_r || ctl.en3;
    ctl.en1    = !v1_r || ctl.en2;
    ctl.accept = in_valid && ctl.en1;
  end

  assign in_ready  = ctl.en1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.en1)    v1_r        <= in_valid;
      if (ctl.en2)    v2_r        <= v1_r;
      if (ctl.en3)    v3_r        <= v2_r;
      if (ctl.en_out) out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= GW'(PROP_GAIN_RST);
      integ_gain_r <= GW'(INTEG_GAIN_RST);
      deriv_gain_r <= GW'(DERIV_GAIN_RST);
      integ_zone_r <= SENSOR_BITS'(INTEG_ZONE_RST);
      integ_cap_r  <= CAP_W'(INTEG_CAP_RST);
      low_ep_r     <= SENSOR_BITS'(LOW_EP_RST);
      high_ep_r    <= SENSOR_BITS'(HIGH_EP_RST);
      cut_band_r   <= SENSOR_BITS'(CUT_BAND_RST);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:     prop_gain_r  <= cfg_wdata[GW-1:0];
        REG_INTEG_GAIN:    integ_gain_r <= cfg_wdata[GW-1:0];
        REG_DERIV_GAIN:    deriv_gain_r <= cfg_wdata[GW-1:0];
        REG_INTEG_ZONE:    integ_zone_r <= cfg_wdata[SENSOR_BITS-1:0];
        REG_INTEG_CAP:     integ_cap_r  <= cfg_wdata[CAP_W-1:0];
        REG_LOW_ENDPOINT:  low_ep_r     <= cfg_wdata[SENSOR_BITS-1:0];
        REG_HIGH_ENDPOINT: high_ep_r    <= cfg_wdata[SENSOR_BITS-1:0];
        REG_CUT_BAND:      cut_band_r   <= cfg_wdata[SENSOR_BITS-1:0];
      endcase
    end
  end

  pwec_update u_update (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_data       (in_data),
    .integ_zone    (integ_zone_r),
    .integ_cap     (integ_cap_r),
    .low_endpoint  (low_ep_r),
    .high_endpoint (high_ep_r),
    .cut_band      (cut_band_r),
    .upd_r         (upd)
  );

  pwec_drive #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_drive (
    .clk        (clk),
    .ctl        (ctl),
    .upd        (upd),
    .prop_gain  (prop_gain_r),
    .integ_gain (integ_gain_r),
    .deriv_gain (deriv_gain_r),
    .out_r      (out_data)
  );

endmodule

// ===== sv/pwec_update.sv =====
// ----------------------------------------------------------------------------
// pwec_update
// Error, integral zone accumulation with saturation and cap, endpoint cutoff.
// ----------------------------------------------------------------------------
module pwec_update (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pwec_pkg::pipe_ctl_t             ctl,
  input  pwec_pkg::in_item_t              in_data,
  input  logic [pwec_pkg::SENSOR_BITS-1:0] integ_zone,
  input  logic [pwec_pkg::CAP_W-1:0]       integ_cap,
  input  logic [pwec_pkg::SENSOR_BITS-1:0] low_endpoint,
  input  logic [pwec_pkg::SENSOR_BITS-1:0] high_endpoint,
  input  logic [pwec_pkg::SENSOR_BITS-1:0] cut_band,
  output pwec_pkg::upd_item_t             upd_r
);
  import pwec_pkg::*;

  logic signed [ERR_W-1:0]   prev_err_r;
  logic signed [TOTAL_W-1:0] total_r;

  logic signed [ERR_W-1:0]   err;
  logic        [ERR_W-1:0]   mag;
  logic signed [TOTAL_W:0]   sum;
  logic signed [TOTAL_W:0]   sat;
  logic signed [TOTAL_W:0]   cap_ext;
  logic signed [TOTAL_W-1:0] total_nxt;
  logic signed [ERR_W-1:0]   dlo;
  logic signed [ERR_W-1:0]   dhi;
  logic        [ERR_W-1:0]   mlo;
  logic        [ERR_W-1:0]   mhi;
  logic                      cut;
  upd_item_t                 upd_nxt;

  always_comb begin
    err = $signed({1'b0, in_data.target_position}) - $signed({1'b0, in_data.measured_position});
    mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    sum = $signed({total_r[TOTAL_W-1], total_r}) + (TOTAL_W+1)'(err);
    // clip back into 32 bits when the add overflowed
    if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
      sat = sum[TOTAL_W] ? {2'b11, {(TOTAL_W-1){1'b0}}} : {2'b00, {(TOTAL_W-1){1'b1}}};
    end else begin
      sat = sum;
    end
    if (err == '0 || mag >= {1'b0, integ_zone}) begin
      sat = '0;
    end
    cap_ext = $signed({2'b00, integ_cap});
    total_nxt = (sat > cap_ext) ? TOTAL_W'(cap_ext) : TOTAL_W'(sat);

    dlo = $signed({1'b0, low_endpoint})  - $signed({1'b0, in_data.measured_position});
    dhi = $signed({1'b0, high_endpoint}) - $signed({1'b0, in_data.measured_position});
    mlo = dlo[ERR_W-1] ? ERR_W'(-dlo) : ERR_W'(dlo);
    mhi = dhi[ERR_W-1] ? ERR_W'(-dhi) : ERR_W'(dhi);
    cut = (in_data.target_position == low_endpoint  && mlo <= {1'b0, cut_band}) ||
          (in_data.target_position == high_endpoint && mhi <= {1'b0, cut_band});

    upd_nxt.err   = err;
    upd_nxt.delta = DELTA_W'(err) - DELTA_W'(prev_err_r);
    upd_nxt.total = total_nxt;
    upd_nxt.cut   = cut;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      total_r    <= '0;
    end else if (ctl.accept) begin
      prev_err_r <= err;
      total_r    <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      upd_r <= upd_nxt;
    end
  end

endmodule

// ===== sv/pwec_drive.sv =====
// ----------------------------------------------------------------------------
// pwec_drive
// Gain multiplies, sum, truncation toward zero, clamp and cutoff.
// ----------------------------------------------------------------------------
module pwec_drive #(
  parameter int GAIN_FRAC_BITS = pwec_pkg::GAIN_FRAC_BITS_DEF,
  localparam int GW = GAIN_FRAC_BITS + pwec_pkg::GAIN_INT_BITS
) (
  input  logic                 clk,
  input  pwec_pkg::pipe_ctl_t  ctl,
  input  pwec_pkg::upd_item_t  upd,
  input  logic [GW-1:0]        prop_gain,
  input  logic [GW-1:0]        integ_gain,
  input  logic [GW-1:0]        deriv_gain,
  output pwec_pkg::out_item_t  out_r
);
  import pwec_pkg::*;

  localparam int PW    = GW + 1 + ERR_W;
  localparam int IW    = GW + 1 + TOTAL_W;
  localparam int DW    = GW + 1 + DELTA_W;
  localparam int ACC_W = IW + 2;
  localparam int QW    = ACC_W - GAIN_FRAC_BITS;
  localparam logic signed [QW-1:0] Q_HI = QW'(DRIVE_LIMIT);
  localparam logic signed [QW-1:0] Q_LO = -Q_HI;

  logic signed [PW-1:0]    p_r;
  logic signed [IW-1:0]    i_r;
  logic signed [DW-1:0]    d_r;
  logic                    cut2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    cut3_r;

  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] biased;
  logic signed [QW-1:0]    q;
  out_item_t               out_nxt;

  // stage 2: three independent products
  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      p_r    <= $signed({1'b0, prop_gain})  * upd.err;
      i_r    <= $signed({1'b0, integ_gain}) * upd.total;
      d_r    <= $signed({1'b0, deriv_gain}) * upd.delta;
      cut2_r <= upd.cut;
    end
  end

  assign acc_nxt = ACC_W'(p_r) + ACC_W'(i_r) + ACC_W'(d_r);

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      acc_r  <= acc_nxt;
      cut3_r <= cut2_r;
    end
  end

  always_comb begin
    // bias negatives by one lsb short of a unit so the shift rounds toward zero
    biased = acc_r + (acc_r[ACC_W-1] ? ACC_W'({GAIN_FRAC_BITS{1'b1}}) : ACC_W'(0));
    q      = biased[ACC_W-1:GAIN_FRAC_BITS];
    out_nxt.endpoint_cut = cut3_r;
    priority if (cut3_r) begin
      out_nxt.drive_level = '0;
    end else if (q > Q_HI) begin
      out_nxt.drive_level = DRIVE_W'(Q_HI);
    end else if (q < Q_LO) begin
      out_nxt.drive_level = DRIVE_W'(Q_LO);
    end else begin
      out_nxt.drive_level = q[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_out) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== sv/pwec_checker.sv =====
// ----------------------------------------------------------------------------
// pwec_checker
// Port-level checks on the controller, bound to the top level.
// ----------------------------------------------------------------------------
module pwec_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pwec_pkg::out_item_t out_data
);
  import pwec_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_cut_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.endpoint_cut |-> out_data.drive_level == '0)
    else $error("cutoff with nonzero drive");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.drive_level != DRIVE_W'(-128))
    else $error("drive outside clamp");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result visible right after reset");

  // an empty output register means the whole pipe can move
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with output empty");

endmodule

bind pid_with_endpoint_cutoff pwec_checker u_pwec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
